// ===== src/tcw_pkg.sv =====
package tcw_pkg;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] CODE_NEWLINE   = 8'd10;
  localparam logic [7:0] CODE_BACKSPACE = 8'd8;
  localparam logic [7:0] BLANK          = 8'h20;

  // wide enough for every grid that the 7-bit column and 5-bit row fields can address
  localparam int MAX_ADDR_W = 15;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_code_t;

  typedef struct packed {
    op_code_t              code;
    logic [7:0]            ch;
    logic [MAX_ADDR_W-1:0] addr;
  } op_t;

  typedef struct packed {
    logic [6:0] col;
    logic [4:0] row;
    logic [7:0] ch;
  } res_t;

  typedef struct packed {
    logic take;
    logic push;
    logic init;
  } back_ctl_t;

endpackage

// ===== src/tcw_fifo.sv =====
module tcw_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/tcw_front.sv =====
module tcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic [1:0]     cmd,
  input  logic [7:0]     char_code,
  input  logic [4:0]     read_row,
  input  logic [6:0]     read_col,
  input  logic           hold,
  output logic           full,
  output logic           op_valid,
  output tcw_pkg::op_t   op,
  input  logic           take
);
  import tcw_pkg::*;

  op_t  op_in;
  logic q_full;
  logic q_empty;
  logic rd_ok;

  assign rd_ok = (int'(read_row) < ROWS) && (int'(read_col) < COLUMNS);

  always_comb begin
    op_in.ch   = char_code;
    op_in.addr = MAX_ADDR_W'(int'(read_row) * COLUMNS + int'(read_col));
    unique case (cmd)
      CMD_PUT: begin
        if (char_code == CODE_NEWLINE) begin
          op_in.code = OP_NEWLINE;
        end else if (char_code == CODE_BACKSPACE) begin
          op_in.code = OP_BACKSPACE;
        end else begin
          op_in.code = OP_CHAR;
        end
      end
      CMD_CLEAR: op_in.code = OP_CLEAR;
      // out-of-range read answers like an unknown command
      CMD_READ:  op_in.code = rd_ok ? OP_READ : OP_NOP;
      default:   op_in.code = OP_NOP;
    endcase
  end

  assign full     = q_full || hold;
  assign op_valid = !q_empty;

  tcw_fifo #(
    .W     ($bits(op_t)),
    .DEPTH (2)
  ) u_op_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !full),
    .wr_data (op_in),
    .full    (q_full),
    .rd_en   (take),
    .rd_data (op),
    .empty   (q_empty)
  );

endmodule

// ===== src/tcw_back.sv =====
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                op_valid,
  input  tcw_pkg::op_t        op,
  input  logic                res_full,
  output tcw_pkg::back_ctl_t  ctl,
  output tcw_pkg::res_t       res
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS + 1);

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_BLANK
  } state_t;

  logic [7:0] grid [CELLS];

  state_t        state, state_next;
  logic [PW-1:0] cnt, cnt_next;
  logic [AW-1:0] dst, dst_next;
  logic          cp_valid, cp_valid_next;
  logic          fill_reply, fill_reply_next;
  logic          pend_char, pend_char_next;
  logic [7:0]    pend_ch, pend_ch_next;
  logic [RW-1:0] row, row_next;
  logic [CW-1:0] col, col_next;
  logic [PW-1:0] pos, pos_next;

  logic          we;
  logic [AW-1:0] wa;
  logic [7:0]    wd;
  logic [AW-1:0] ra;
  logic [7:0]    rdata;
  logic [PW-1:0] pos_dec;
  logic          at_end;
  logic          take;
  logic          push;
  logic [7:0]    res_ch;

  assign pos_dec = pos - PW'(1);
  assign at_end  = (row == RW'(ROWS));

  always_ff @(posedge clk) begin
    if (we) begin
      grid[wa] <= wd;
    end
    rdata <= grid[ra];
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    dst_next        = dst;
    cp_valid_next   = 1'b0;
    fill_reply_next = fill_reply;
    pend_char_next  = pend_char;
    pend_ch_next    = pend_ch;
    row_next        = row;
    col_next        = col;
    pos_next        = pos;
    we              = 1'b0;
    wa              = dst;
    wd              = BLANK;
    ra              = cnt[AW-1:0];
    take            = 1'b0;
    push            = 1'b0;
    res_ch          = 8'd0;

    unique case (state)
      S_FILL: begin
        we       = 1'b1;
        wa       = cnt[AW-1:0];
        cnt_next = cnt + PW'(1);
        if (cnt == PW'(CELLS - 1)) begin
          state_next      = S_IDLE;
          cnt_next        = '0;
          push            = fill_reply;
          fill_reply_next = 1'b0;
        end
      end

      S_IDLE: begin
        ra = op.addr[AW-1:0];
        if (op_valid && !res_full) begin
          take = 1'b1;
          unique case (op.code)
            OP_CHAR: begin
              if (at_end) begin
                state_next     = S_SCROLL;
                cnt_next       = PW'(COLUMNS);
                pend_char_next = 1'b1;
                pend_ch_next   = op.ch;
                row_next       = RW'(ROWS - 1);
                col_next       = CW'(1);
                pos_next       = PW'(CELLS - COLUMNS + 1);
              end else begin
                we       = 1'b1;
                wa       = pos[AW-1:0];
                wd       = op.ch;
                pos_next = pos + PW'(1);
                if (col == CW'(COLUMNS - 1)) begin
                  col_next = '0;
                  row_next = row + RW'(1);
                end else begin
                  col_next = col + CW'(1);
                end
                push = 1'b1;
              end
            end
            OP_NEWLINE: begin
              if (row >= RW'(ROWS - 1)) begin
                state_next     = S_SCROLL;
                cnt_next       = PW'(COLUMNS);
                pend_char_next = 1'b0;
                row_next       = RW'(ROWS - 1);
                col_next       = '0;
                pos_next       = PW'(CELLS - COLUMNS);
              end else begin
                row_next = row + RW'(1);
                col_next = '0;
                pos_next = pos - PW'(col) + PW'(COLUMNS);
                push     = 1'b1;
              end
            end
            OP_BACKSPACE: begin
              if (pos != '0) begin
                pos_next = pos_dec;
                we       = 1'b1;
                wa       = pos_dec[AW-1:0];
                if (col == '0) begin
                  col_next = CW'(COLUMNS - 1);
                  row_next = row - RW'(1);
                end else begin
                  col_next = col - CW'(1);
                end
              end
              push = 1'b1;
            end
            OP_CLEAR: begin
              state_next      = S_FILL;
              cnt_next        = '0;
              fill_reply_next = 1'b1;
              row_next        = '0;
              col_next        = '0;
              pos_next        = '0;
            end
            OP_READ: begin
              state_next = S_READ;
            end
            default: begin
              push = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        push       = 1'b1;
        res_ch     = rdata;
        state_next = S_IDLE;
      end

      // read row r+1 while writing the previous cell one row up
      S_SCROLL: begin
        if (cp_valid) begin
          we = 1'b1;
          wa = dst;
          wd = rdata;
        end
        if (cnt != PW'(CELLS)) begin
          cnt_next      = cnt + PW'(1);
          cp_valid_next = 1'b1;
          dst_next      = AW'(cnt - PW'(COLUMNS));
        end else begin
          state_next = S_BLANK;
          cnt_next   = PW'(CELLS - COLUMNS);
        end
      end

      S_BLANK: begin
        we       = 1'b1;
        wa       = cnt[AW-1:0];
        wd       = (pend_char && cnt == PW'(CELLS - COLUMNS)) ? pend_ch : BLANK;
        cnt_next = cnt + PW'(1);
        if (cnt == PW'(CELLS - 1)) begin
          state_next = S_IDLE;
          cnt_next   = '0;
          push       = 1'b1;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  assign ctl.take = take;
  assign ctl.push = push;
  assign ctl.init = (state == S_FILL) && !fill_reply;

  assign res.col = 7'(col_next);
  assign res.row = 5'(row_next);
  assign res.ch  = res_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      cnt        <= '0;
      cp_valid   <= 1'b0;
      fill_reply <= 1'b0;
      pend_char  <= 1'b0;
      row        <= '0;
      col        <= '0;
      pos        <= '0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      cp_valid   <= cp_valid_next;
      fill_reply <= fill_reply_next;
      pend_char  <= pend_char_next;
      row        <= row_next;
      col        <= col_next;
      pos        <= pos_next;
    end
    dst     <= dst_next;
    pend_ch <= pend_ch_next;
  end

endmodule

// ===== src/text_console_writer.sv =====
// Path: an accepted item passes the op queue, the back end and the result queue; a read
//   adds the S_READ state for the registered grid read; a scroll or a clear walks the grid.
// Throughput: one plain put per cycle while the result queue has room; the back end runs
//   one item at a time on the grid memory, so scroll and clear hold it for the whole walk.
// Reset (synchronous, rst high): cursor homes, then a pass blanks the grid to spaces; full
//   stays high during that pass.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] cmd,
  input  logic [7:0] char_code,
  input  logic [4:0] read_row,
  input  logic [6:0] read_col,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] cursor_col,
  output logic [4:0] cursor_row,
  output logic [7:0] cell_char
);
  import tcw_pkg::*;

  logic      op_valid;
  op_t       op;
  back_ctl_t ctl;
  res_t      res_in;
  res_t      res_out;
  logic      res_full;

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .cmd       (cmd),
    .char_code (char_code),
    .read_row  (read_row),
    .read_col  (read_col),
    .hold      (ctl.init),
    .full      (full),
    .op_valid  (op_valid),
    .op        (op),
    .take      (ctl.take)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op       (op),
    .res_full (res_full),
    .ctl      (ctl),
    .res      (res_in)
  );

  tcw_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (ctl.push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign cursor_col = res_out.col;
  assign cursor_row = res_out.row;
  assign cell_char  = res_out.ch;

  // a result never lands on a full result queue
  a_no_res_overflow: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> !res_full)
    else $error("result pushed into full queue");

  // back end only dequeues work that is there
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.take |-> op_valid)
    else $error("op taken from empty queue");

  // no item is accepted while the grid is being blanked after reset
  a_init_blocks: assert property (@(posedge clk) disable iff (rst)
    ctl.init |-> full)
    else $error("input open during reset fill");

endmodule

// ===== sim/tb_text_console_writer.sv =====
`timescale 1ns / 1ps

module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam logic [1:0] CMD_NONE = 2'd3;  // unknown command, changes nothing
  localparam int QUIET_LIMIT = 20000;      // covers the reset clearing pass and a scroll

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] cmd = CMD_PUT;
  logic [7:0] char_code = '0;
  logic [4:0] read_row = '0;
  logic [6:0] read_col = '0;
  logic       empty;
  logic       pop = 1'b0;
  logic [6:0] cursor_col;
  logic [4:0] cursor_row;
  logic [7:0] cell_char;

  text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_top (.*);

  always #4 clk = ~clk;

  // console shadow: grid contents and linear write position
  logic [7:0]  screen [CELLS];
  int unsigned write_pos;
  res_t        cursor_q[$];
  res_t        want;
  int          errors = 0;
  int          quiet = 0;
  bit          stall_en = 1'b1;

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen[i] = BLANK;
    write_pos = 0;
  endfunction

  function automatic void scroll_up();
    for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = BLANK;
    write_pos = CELLS - COLUMNS;
  endfunction

  function automatic res_t console_step(logic [1:0] c, logic [7:0] ch,
                                        logic [4:0] r, logic [6:0] col);
    res_t       res;
    logic [7:0] rd_ch;
    rd_ch = '0;
    case (c)
      CMD_PUT: begin
        if (ch == CODE_NEWLINE) begin
          write_pos += COLUMNS - (write_pos % COLUMNS);
          if (write_pos >= CELLS) scroll_up();
        end else if (ch == CODE_BACKSPACE) begin
          if (write_pos > 0) begin
            write_pos--;
            screen[write_pos] = BLANK;
          end
        end else begin
          if (write_pos >= CELLS) scroll_up();
          screen[write_pos] = ch;
          write_pos++;
        end
      end
      CMD_CLEAR: blank_screen();
      CMD_READ: begin
        if (r < ROWS && col < COLUMNS) rd_ch = screen[r * COLUMNS + col];
      end
      default: ;
    endcase
    res.col = 7'(write_pos % COLUMNS);
    res.row = 5'(write_pos / COLUMNS);
    res.ch  = rd_ch;
    return res;
  endfunction

  // push stays high after acceptance; the next call or release drives it
  task automatic send_item(logic [1:0] c, logic [7:0] ch, logic [4:0] r, logic [6:0] col);
    while (stall_en && $urandom_range(99) < 12) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    cmd       <= c;
    char_code <= ch;
    read_row  <= r;
    read_col  <= col;
    @(posedge clk);
    while (full) @(posedge clk);
    cursor_q.push_back(console_step(c, ch, r, col));
  endtask

  task automatic put_char(logic [7:0] ch);
    send_item(CMD_PUT, ch, 5'($urandom), 7'($urandom));
  endtask

  task automatic read_cell(int r, int c);
    send_item(CMD_READ, 8'($urandom), 5'(r), 7'(c));
  endtask

  task automatic wait_all_results();
    push <= 1'b0;
    while (cursor_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_glyph();
    logic [7:0] ch;
    do ch = 8'($urandom); while (ch == CODE_NEWLINE || ch == CODE_BACKSPACE);
    return ch;
  endfunction

  task automatic test_put_and_read();
    put_char(CODE_BACKSPACE);  // at home: no move
    put_char(8'h48);
    put_char(8'hFF);
    put_char(8'h00);
    read_cell(0, 0);
    read_cell(0, 1);
    read_cell(0, 2);
    read_cell(0, 3);
    put_char(CODE_NEWLINE);
    put_char(8'h78);
    put_char(CODE_BACKSPACE);
    put_char(CODE_BACKSPACE);  // wraps back to the end of row 0
    read_cell(0, COLUMNS - 1);
    read_cell(ROWS, 0);
    read_cell(0, COLUMNS);
    read_cell(31, 127);
    send_item(CMD_NONE, 8'hFF, 5'h1F, 7'h7F);
    send_item(CMD_NONE, 8'h00, 5'h00, 7'h00);
    send_item(CMD_CLEAR, 8'hA5, 5'h15, 7'h55);
    read_cell(0, 1);
  endtask

  task automatic fill_bottom_row();
    for (int i = 0; i < COLUMNS; i++) put_char(rand_glyph());
  endtask

  task automatic test_grid_end();
    send_item(CMD_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
    repeat (ROWS - 1) put_char(CODE_NEWLINE);
    fill_bottom_row();              // cursor row now reads ROWS
    read_cell(ROWS - 1, COLUMNS - 1);
    put_char(CODE_BACKSPACE);       // back onto the last cell
    read_cell(ROWS - 1, COLUMNS - 1);
    put_char(rand_glyph());
    put_char(CODE_NEWLINE);         // newline past the end scrolls
    read_cell(ROWS - 2, COLUMNS - 1);
    read_cell(ROWS - 1, 0);
    fill_bottom_row();
    put_char(8'h7E);                // scrolls, then stores at bottom row start
    read_cell(ROWS - 2, 0);
    read_cell(ROWS - 1, 0);
    read_cell(ROWS - 1, 1);
    put_char(CODE_NEWLINE);         // mid bottom row: scrolls too
    read_cell(ROWS - 2, 0);
    wait_all_results();
  endtask

  task automatic test_random();
    int pick;
    for (int n = 0; n < 800; n++) begin
      stall_en = !(n >= 350 && n < 600);
      if (n == 700) wait_all_results();
      pick = $urandom_range(99);
      if (pick < 45)      put_char(rand_glyph());
      else if (pick < 55) put_char(CODE_NEWLINE);
      else if (pick < 62) put_char(CODE_BACKSPACE);
      else if (pick < 64) send_item(CMD_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
      else if (pick < 86) read_cell($urandom_range(ROWS - 1), $urandom_range(COLUMNS - 1));
      else if (pick < 92) send_item(CMD_READ, 8'($urandom), 5'($urandom), 7'($urandom));
      else if (pick < 96) send_item(CMD_NONE, 8'($urandom), 5'($urandom), 7'($urandom));
      else                put_char(8'($urandom));
    end
    stall_en = 1'b1;
  endtask

  initial begin
    blank_screen();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_put_and_read();
    test_grid_end();
    test_random();
    wait_all_results();
    repeat (CELLS + 50) @(posedge clk);
    if (errors == 0 && cursor_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else     pop <= !(stall_en && $urandom_range(99) < 12);
  end

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      if (errors < 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (cursor_q.size() == 0) begin
        if (errors < 10)
          $display("%0t: unexpected item: col %0d row %0d char %0d",
                   $realtime, cursor_col, cursor_row, cell_char);
        errors++;
      end else begin
        want = cursor_q.pop_front();
        check_field("cursor_col", want.col, cursor_col);
        check_field("cursor_row", want.row, cursor_row);
        check_field("cell_char", want.ch, cell_char);
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule
